>>> sv/scci_pkg.sv
package scci_pkg;

	localparam int MAX_ROWS     = 1024;
	localparam int MAX_NONZEROS = 65536;
	localparam int MAX_COLS     = 65536;

	localparam int ROW_W   = 11;
	localparam int COL_W   = 16;
	localparam int VAL_W   = 32;
	localparam int CNT_W   = 17;
	localparam int NCOL_W  = 17;
	localparam int POS_W   = 16;
	localparam int SLOT_W  = 26;
	localparam int PROD_W  = CNT_W + ROW_W;
	localparam int TBL_DEPTH = MAX_ROWS + 1;
	localparam int TBL_IDX_W = $clog2(TBL_DEPTH);
	localparam int CFG_W   = 17;

	localparam int IN_DATA_W  = 64;
	localparam int OUT_DATA_W = 128;

	typedef enum logic [1:0] {
		MODE_LOAD    = 2'd0,
		MODE_READ    = 2'd1,
		MODE_RESTART = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_ORDER = 2'd1,
		ST_RANGE = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	typedef enum logic [0:0] {
		REG_ROWS = 1'b0,
		REG_COLS = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_FILL_HEAD,
		S_FINISH,
		S_FILL_TAIL,
		S_RESULT
	} state_t;

	typedef struct packed {
		logic capture;
		logic eval;
		logic fill_step;
		logic tail_start;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic head_needed;
		logic tail_needed;
		logic tail_pending;
		logic fill_last;
		logic out_free;
	} sts_t;

endpackage

>>> sv/sparse_coo_to_csr_ell_indexer_top.sv
// Converts a stream of row-major sorted COO nonzeros into CSR positions and
// column-major ELL slots, keeps the longest row seen so far, and builds the
// CSR row pointer table, which a read request returns. Each request with
// tuser 0 loads one entry, 1 reads one row pointer and 2 restarts the
// conversion. A request is accepted, evaluated and loaded into the output
// register; in between, an entry that opens a new row writes the pointers
// of all rows it crosses, and the final entry passes a finishing step and
// then writes the pointers of the remaining rows up to the configured row
// count, all through the single write port of the table. A new request is
// taken while the previous result still waits in the output register. Bad
// entries are skipped and reported in the result status. No clearing pass
// follows reset.
module sparse_coo_to_csr_ell_indexer_top
	import scci_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [0:0]            cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// row [10:0], col [26:11], value [58:27], zero fill above.
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// mode.
	input  logic [1:0]            s_tuser,
	input  logic                  s_tlast,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// csr_position [15:0], ell_slot [41:16], col_out [57:42], value_out [89:58],
	// row_start [106:90], longest_row [123:107], zero fill above.
	output logic [OUT_DATA_W-1:0] m_tdata,
	// status.
	output logic [1:0]            m_tuser
);

	cmd_t cmd;
	sts_t sts;

	logic [POS_W-1:0]  csr_position;
	logic [SLOT_W-1:0] ell_slot;
	logic [COL_W-1:0]  col_out;
	logic [VAL_W-1:0]  value_out;
	logic [CNT_W-1:0]  row_start;
	logic [CNT_W-1:0]  longest_row;

	scci_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	scci_datapath u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_mode          (s_tuser),
		.in_row           (s_tdata[ROW_W-1:0]),
		.in_col           (s_tdata[ROW_W+COL_W-1:ROW_W]),
		.in_value         (s_tdata[ROW_W+COL_W+VAL_W-1:ROW_W+COL_W]),
		.in_last          (s_tlast),
		.out_valid        (m_tvalid),
		.out_ready        (m_tready),
		.out_csr_position (csr_position),
		.out_ell_slot     (ell_slot),
		.out_col          (col_out),
		.out_value        (value_out),
		.out_row_start    (row_start),
		.out_longest_row  (longest_row),
		.out_status       (m_tuser)
	);

	assign m_tdata = {4'b0, longest_row, row_start, value_out, col_out, ell_slot, csr_position};

endmodule

>>> sv/scci_ctrl.sv
module scci_ctrl
	import scci_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_EVAL;
			end
			S_EVAL: begin
				priority if (sts.head_needed) state_d = S_FILL_HEAD;
				else if (sts.tail_needed) state_d = S_FINISH;
				else state_d = S_RESULT;
			end
			S_FILL_HEAD: begin
				if (sts.fill_last) state_d = sts.tail_pending ? S_FINISH : S_RESULT;
			end
			S_FINISH: begin
				state_d = S_FILL_TAIL;
			end
			S_FILL_TAIL: begin
				if (sts.fill_last) state_d = S_RESULT;
			end
			S_RESULT: begin
				if (sts.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.capture = in_valid;
			end
			S_EVAL:      cmd.eval = 1'b1;
			S_FILL_HEAD: cmd.fill_step = 1'b1;
			S_FINISH:    cmd.tail_start = 1'b1;
			S_FILL_TAIL: cmd.fill_step = 1'b1;
			S_RESULT:    cmd.load_out = sts.out_free;
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

>>> sv/scci_datapath.sv
module scci_datapath
	import scci_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output sts_t                  sts,
	input  logic                  cfg_we,
	input  logic [0:0]            cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	input  logic [1:0]            in_mode,
	input  logic [ROW_W-1:0]      in_row,
	input  logic [COL_W-1:0]      in_col,
	input  logic [VAL_W-1:0]      in_value,
	input  logic                  in_last,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [POS_W-1:0]      out_csr_position,
	output logic [SLOT_W-1:0]     out_ell_slot,
	output logic [COL_W-1:0]      out_col,
	output logic [VAL_W-1:0]      out_value,
	output logic [CNT_W-1:0]      out_row_start,
	output logic [CNT_W-1:0]      out_longest_row,
	output logic [1:0]            out_status
);

	logic [ROW_W-1:0]  rows_cfg_q;
	logic [NCOL_W-1:0] cols_cfg_q;
	logic [ROW_W-1:0]  cur_row_q;
	logic [COL_W-1:0]  prev_col_q;
	logic [CNT_W-1:0]  entries_q;
	logic [CNT_W-1:0]  row_count_q;
	logic [CNT_W-1:0]  longest_q;
	logic              started_q;
	logic              finished_q;
	logic              tail_pending_q;
	logic              out_valid_q;

	logic [1:0]        mode_q;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;
	logic [VAL_W-1:0]  value_q;
	logic              last_q;

	logic [TBL_IDX_W-1:0] fill_idx_q;
	logic [TBL_IDX_W-1:0] fill_hi_q;
	logic [CNT_W-1:0]     fill_val_q;

	logic [CNT_W-1:0]  table_mem [TBL_DEPTH];
	logic [CNT_W-1:0]  rd_data_q;

	logic [POS_W-1:0]  res_pos_q;
	logic [SLOT_W-1:0] res_prod_q;
	logic [COL_W-1:0]  res_col_q;
	logic [VAL_W-1:0]  res_val_q;
	logic [1:0]        res_status_q;
	logic              res_entry_q;
	logic              res_read_q;

	logic [POS_W-1:0]  o_pos_q;
	logic [SLOT_W-1:0] o_slot_q;
	logic [COL_W-1:0]  o_col_q;
	logic [VAL_W-1:0]  o_val_q;
	logic [CNT_W-1:0]  o_rstart_q;
	logic [CNT_W-1:0]  o_longest_q;
	logic [1:0]        o_status_q;

	logic [ROW_W-1:0]  nr;
	logic [NCOL_W-1:0] nc;
	logic              new_row;
	logic              range_bad;
	logic              order_bad;
	logic              full;
	status_t           eval_status;
	logic              entry_ok;
	logic [CNT_W-1:0]  base_count;
	logic [CNT_W-1:0]  next_count;
	logic [PROD_W-1:0] prod;

	always_comb begin
		priority if (rows_cfg_q == '0) nr = ROW_W'(1);
		else if (rows_cfg_q > ROW_W'(MAX_ROWS)) nr = ROW_W'(MAX_ROWS);
		else nr = rows_cfg_q;
		priority if (cols_cfg_q == '0) nc = NCOL_W'(1);
		else if (cols_cfg_q > NCOL_W'(MAX_COLS)) nc = NCOL_W'(MAX_COLS);
		else nc = cols_cfg_q;
	end

	always_comb begin
		new_row    = !started_q || (row_q > cur_row_q);
		range_bad  = (row_q >= nr) || ({1'b0, col_q} >= nc);
		order_bad  = started_q && ((row_q < cur_row_q) ||
		             ((row_q == cur_row_q) && (col_q <= prev_col_q)));
		full       = entries_q >= CNT_W'(MAX_NONZEROS);
		base_count = new_row ? '0 : row_count_q;
		next_count = base_count + CNT_W'(1);
		prod       = PROD_W'(base_count) * PROD_W'(nr);
		unique case (mode_q)
			MODE_LOAD: begin
				priority if (finished_q) eval_status = ST_FULL;
				else if (range_bad) eval_status = ST_RANGE;
				else if (order_bad) eval_status = ST_ORDER;
				else if (full) eval_status = ST_FULL;
				else eval_status = ST_OK;
			end
			MODE_READ:    eval_status = (row_q > nr) ? ST_RANGE : ST_OK;
			MODE_RESTART: eval_status = ST_OK;
			default:      eval_status = ST_RANGE;
		endcase
		entry_ok = (mode_q == MODE_LOAD) && !finished_q && (eval_status == ST_OK);
	end

	assign sts.head_needed  = entry_ok && new_row;
	assign sts.tail_needed  = (mode_q == MODE_LOAD) && !finished_q && last_q;
	assign sts.tail_pending = tail_pending_q;
	assign sts.fill_last    = fill_idx_q == fill_hi_q;
	assign sts.out_free     = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_cfg_q     <= ROW_W'(1);
			cols_cfg_q     <= NCOL_W'(1);
			cur_row_q      <= '0;
			prev_col_q     <= '0;
			entries_q      <= '0;
			row_count_q    <= '0;
			longest_q      <= '0;
			started_q      <= 1'b0;
			finished_q     <= 1'b0;
			tail_pending_q <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_ROWS: rows_cfg_q <= cfg_data[ROW_W-1:0];
					REG_COLS: cols_cfg_q <= cfg_data[NCOL_W-1:0];
					default: ;
				endcase
			end
			if (cmd.eval) begin
				tail_pending_q <= sts.tail_needed;
				if (entry_ok) begin
					row_count_q <= next_count;
					if (next_count > longest_q) longest_q <= next_count;
					entries_q  <= entries_q + CNT_W'(1);
					prev_col_q <= col_q;
					cur_row_q  <= row_q;
					started_q  <= 1'b1;
				end
				if (mode_q == MODE_RESTART) begin
					cur_row_q   <= '0;
					prev_col_q  <= '0;
					entries_q   <= '0;
					row_count_q <= '0;
					longest_q   <= '0;
					started_q   <= 1'b0;
					finished_q  <= 1'b0;
				end
			end
			if (cmd.tail_start) finished_q <= 1'b1;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q  <= in_mode;
			row_q   <= in_row;
			col_q   <= in_col;
			value_q <= in_value;
			last_q  <= in_last;
		end
		if (cmd.eval) begin
			res_pos_q    <= entries_q[POS_W-1:0];
			res_prod_q   <= prod[SLOT_W-1:0];
			res_col_q    <= col_q;
			res_val_q    <= value_q;
			res_status_q <= eval_status;
			res_entry_q  <= entry_ok;
			res_read_q   <= (mode_q == MODE_READ) && (eval_status == ST_OK);
		end
		priority if (cmd.eval && sts.head_needed) begin
			fill_idx_q <= started_q ? cur_row_q + TBL_IDX_W'(1) : '0;
			fill_hi_q  <= row_q;
			fill_val_q <= started_q ? entries_q : '0;
		end else if (cmd.tail_start) begin
			if (started_q) begin
				fill_idx_q <= (cur_row_q < nr) ? cur_row_q + TBL_IDX_W'(1) : nr;
				fill_val_q <= entries_q;
			end else begin
				fill_idx_q <= '0;
				fill_val_q <= '0;
			end
			fill_hi_q <= nr;
		end else if (cmd.fill_step) begin
			fill_idx_q <= fill_idx_q + TBL_IDX_W'(1);
		end
		if (cmd.load_out) begin
			o_pos_q     <= res_entry_q ? res_pos_q : '0;
			o_slot_q    <= res_entry_q ? res_prod_q + SLOT_W'(row_q) : '0;
			o_col_q     <= res_entry_q ? res_col_q : '0;
			o_val_q     <= res_entry_q ? res_val_q : '0;
			o_rstart_q  <= res_read_q ? rd_data_q : '0;
			o_longest_q <= longest_q;
			o_status_q  <= res_status_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fill_step) begin
			table_mem[fill_idx_q] <= fill_val_q;
		end else if (cmd.eval && (mode_q == MODE_RESTART)) begin
			table_mem[0] <= '0;
		end
		rd_data_q <= table_mem[row_q];
	end

	assign out_valid        = out_valid_q;
	assign out_csr_position = o_pos_q;
	assign out_ell_slot     = o_slot_q;
	assign out_col          = o_col_q;
	assign out_value        = o_val_q;
	assign out_row_start    = o_rstart_q;
	assign out_longest_row  = o_longest_q;
	assign out_status       = o_status_q;

endmodule

>>> tb/tb_sparse_coo_to_csr_ell_indexer_top.sv
module tb_sparse_coo_to_csr_ell_indexer_top;
	import scci_pkg::*;

	localparam logic [1:0] MODE_SPARE = 2'd3;

	typedef struct packed {
		logic [1:0]  mode;
		logic [10:0] row;
		logic [15:0] col;
		logic [31:0] value;
		logic        last;
	} req_t;

	typedef struct packed {
		logic [15:0] csr_pos;
		logic [25:0] ell_slot;
		logic [15:0] col;
		logic [31:0] value;
		logic [16:0] row_start;
		logic [16:0] longest;
		status_t     status;
	} result_t;

	typedef struct {
		bit         is_cfg;
		reg_idx_t   ridx;
		logic [16:0] cdata;
		req_t       rq;
		bit         typed;
		result_t    want;
	} dir_row_t;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [0:0]            cfg_index = '0;
	logic [CFG_W-1:0]      cfg_data = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [1:0]            s_tuser = '0;
	logic                  s_tlast = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [1:0]            m_tuser;

	sparse_coo_to_csr_ell_indexer_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// Predicted converter state, mirroring the block after reset.
	logic [10:0] reg_rows = 11'd1;
	logic [16:0] reg_cols = 17'd1;
	logic [16:0] ptr_tab [0:MAX_ROWS];
	bit          ptr_set [0:MAX_ROWS];
	logic [10:0] cur_row = '0;
	logic [15:0] prev_col = '0;
	logic [16:0] taken = '0;
	logic [16:0] row_count = '0;
	logic [16:0] longest = '0;
	bit          started = 1'b0;
	bit          finished = 1'b0;

	result_t     pending_results [$];
	dir_row_t    directed [$];
	int unsigned requests_sent = 0;
	int unsigned results_seen = 0;
	int unsigned mismatches = 0;
	int unsigned conversions = 0;
	bit          no_idle = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("Verification failed");
		$finish;
	end

	function automatic int unsigned rows_eff();
		if (reg_rows == 0) return 1;
		if (reg_rows > MAX_ROWS) return MAX_ROWS;
		return reg_rows;
	endfunction

	function automatic int unsigned cols_eff();
		if (reg_cols == 0) return 1;
		if (reg_cols > MAX_COLS) return MAX_COLS;
		return reg_cols;
	endfunction

	function automatic void fill_ptrs(input int unsigned lo, input int unsigned hi,
			input logic [16:0] v);
		for (int unsigned r = lo; r <= hi && r <= MAX_ROWS; r++) begin
			ptr_tab[r] = v;
			ptr_set[r] = 1'b1;
		end
	endfunction

	function automatic void close_conversion(input int unsigned nr);
		if (started) begin
			if (cur_row < nr)
				fill_ptrs(cur_row + 1, nr, taken);
			else
				fill_ptrs(nr, nr, taken);
		end else begin
			fill_ptrs(0, nr, '0);
		end
		finished = 1'b1;
		conversions++;
	endfunction

	function automatic result_t convert_request(input req_t rq);
		result_t o;
		int unsigned nr, nc;
		longint unsigned prod;
		o = '0;
		o.status = ST_OK;
		nr = rows_eff();
		nc = cols_eff();
		case (rq.mode)
			MODE_LOAD: begin
				if (finished) begin
					o.status = ST_FULL;
				end else begin
					if (rq.row >= nr || rq.col >= nc)
						o.status = ST_RANGE;
					else if (started && (rq.row < cur_row ||
							(rq.row == cur_row && rq.col <= prev_col)))
						o.status = ST_ORDER;
					else if (taken >= MAX_NONZEROS)
						o.status = ST_FULL;
					if (o.status == ST_OK) begin
						if (!started) begin
							fill_ptrs(0, rq.row, '0);
							row_count = '0;
						end else if (rq.row > cur_row) begin
							fill_ptrs(cur_row + 1, rq.row, taken);
							row_count = '0;
						end
						prod = longint'(row_count) * nr + rq.row;
						o.csr_pos = taken[15:0];
						o.ell_slot = prod[25:0];
						o.col = rq.col;
						o.value = rq.value;
						row_count = row_count + 17'd1;
						if (row_count > longest) longest = row_count;
						taken = taken + 17'd1;
						prev_col = rq.col;
						cur_row = rq.row;
						started = 1'b1;
					end
					if (rq.last) close_conversion(nr);
				end
			end
			MODE_READ: begin
				if (rq.row > nr)
					o.status = ST_RANGE;
				else
					o.row_start = ptr_tab[rq.row];
			end
			MODE_RESTART: begin
				cur_row = '0;
				prev_col = '0;
				taken = '0;
				row_count = '0;
				longest = '0;
				started = 1'b0;
				finished = 1'b0;
				ptr_tab[0] = '0;
				ptr_set[0] = 1'b1;
			end
			default: o.status = ST_RANGE;
		endcase
		o.longest = longest;
		return o;
	endfunction

	function automatic req_t mk_req(input logic [1:0] m, input logic [10:0] r,
			input logic [15:0] c, input logic [31:0] v, input logic l);
		req_t q;
		q.mode = m;
		q.row = r;
		q.col = c;
		q.value = v;
		q.last = l;
		return q;
	endfunction

	function automatic result_t res(input logic [15:0] p, input logic [25:0] s,
			input logic [15:0] c, input logic [31:0] v, input logic [16:0] rs,
			input logic [16:0] lg, input status_t st);
		result_t o;
		o.csr_pos = p;
		o.ell_slot = s;
		o.col = c;
		o.value = v;
		o.row_start = rs;
		o.longest = lg;
		o.status = st;
		return o;
	endfunction

	function automatic dir_row_t cfg_step(input reg_idx_t idx, input logic [16:0] d);
		dir_row_t e;
		e.is_cfg = 1'b1;
		e.ridx = idx;
		e.cdata = d;
		e.rq = '0;
		e.typed = 1'b0;
		e.want = '0;
		return e;
	endfunction

	function automatic dir_row_t req_step(input req_t rq);
		dir_row_t e;
		e.is_cfg = 1'b0;
		e.ridx = REG_ROWS;
		e.cdata = '0;
		e.rq = rq;
		e.typed = 1'b0;
		e.want = '0;
		return e;
	endfunction

	function automatic dir_row_t req_typed(input req_t rq, input result_t w);
		dir_row_t e;
		e = req_step(rq);
		e.typed = 1'b1;
		e.want = w;
		return e;
	endfunction

	// Next entry of a sorted stream; when the last cell is used up it repeats it.
	function automatic req_t wellformed_entry();
		int unsigned nr, nc, r, c, room;
		nr = rows_eff();
		nc = cols_eff();
		r = cur_row;
		c = prev_col;
		if (!started) begin
			if ($urandom_range(0, 3) == 0)
				r = $urandom_range(0, nr - 1);
			else
				r = $urandom_range(0, (nr - 1 < 3) ? nr - 1 : 3);
			if ($urandom_range(0, 1) == 0)
				c = $urandom_range(0, nc - 1);
			else
				c = $urandom_range(0, (nc - 1 < 3) ? nc - 1 : 3);
		end else if (prev_col + 1 < nc && (cur_row + 1 >= nr || $urandom_range(0, 2) != 0)) begin
			room = nc - 2 - prev_col;
			c = prev_col + 1 + $urandom_range(0, (room < 2) ? room : 2);
		end else if (cur_row + 1 < nr) begin
			room = nr - 2 - cur_row;
			if ($urandom_range(0, 5) == 0)
				r = cur_row + 1 + $urandom_range(0, room);
			else
				r = cur_row + 1 + $urandom_range(0, (room < 1) ? room : 1);
			if ($urandom_range(0, 1) == 0)
				c = $urandom_range(0, nc - 1);
			else
				c = $urandom_range(0, (nc - 1 < 3) ? nc - 1 : 3);
		end
		return mk_req(MODE_LOAD, r[10:0], c[15:0], $urandom, 1'b0);
	endfunction

	function automatic req_t noise_entry();
		int unsigned nr, nc, r, c;
		nr = rows_eff();
		nc = cols_eff();
		case ($urandom_range(0, 3))
			0: begin
				r = $urandom_range(0, 2047);
				c = $urandom_range(0, 65535);
			end
			1: begin
				r = cur_row;
				c = prev_col;
			end
			2: begin
				if (nc > 65535) begin
					r = nr;
					c = $urandom_range(0, 65535);
				end else begin
					r = nr - 1;
					c = nc;
				end
			end
			default: begin
				r = (cur_row > 0) ? $urandom_range(0, cur_row - 1) : 0;
				c = $urandom_range(0, nc - 1);
			end
		endcase
		return mk_req(MODE_LOAD, r[10:0], c[15:0], $urandom, 1'b0);
	endfunction

	// Pointers never written since reset are not read; such picks go out of range.
	function automatic req_t pointer_read();
		int unsigned nr, r;
		nr = rows_eff();
		if ($urandom_range(0, 4) == 0)
			r = $urandom_range(0, 2047);
		else
			r = $urandom_range(0, nr + 1);
		if (r <= nr && !ptr_set[r]) r = nr + 1;
		return mk_req(MODE_READ, r[10:0], 16'($urandom), $urandom, 1'($urandom));
	endfunction

	task automatic report_mismatch(input string what, input longint unsigned got,
			input longint unsigned want);
		mismatches++;
		if (mismatches <= 100)
			$display("MISMATCH %s at result %0d: got %0h, expected %0h",
				what, results_seen, got, want);
	endtask

	task automatic push_request(input req_t rq, input bit typed = 1'b0,
			input result_t want = '0);
		result_t model;
		if (!no_idle && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		s_tdata <= {5'b0, rq.value, rq.col, rq.row};
		s_tuser <= rq.mode;
		s_tlast <= rq.last;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		model = convert_request(rq);
		pending_results.push_back(typed ? want : model);
		requests_sent++;
	endtask

	task automatic wait_results_drained();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [16:0] data, input bit more);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_we <= 1'b1;
		@(posedge clk);
		if (idx == REG_ROWS)
			reg_rows = data[10:0];
		else
			reg_cols = data;
		if (!more) cfg_we <= 1'b0;
	endtask

	task automatic run_conversion();
		logic [16:0] rows_v, cols_v;
		int unsigned n_entries;
		req_t rq;
		case ($urandom_range(0, 9))
			0: rows_v = '0;
			1: rows_v = 17'd2047;
			2: rows_v = 17'd1024;
			3: rows_v = 17'($urandom_range(0, 131071));
			default: rows_v = 17'($urandom_range(1, 12));
		endcase
		case ($urandom_range(0, 9))
			0: cols_v = '0;
			1: cols_v = 17'd131071;
			2: cols_v = 17'd65536;
			3: cols_v = 17'($urandom_range(0, 131071));
			default: cols_v = 17'($urandom_range(1, 40));
		endcase
		wait_results_drained();
		case ($urandom_range(0, 3))
			0: write_reg(REG_ROWS, rows_v, 1'b0);
			1: write_reg(REG_COLS, cols_v, 1'b0);
			default: begin
				write_reg(REG_ROWS, rows_v, 1'b1);
				write_reg(REG_COLS, cols_v, 1'b0);
			end
		endcase
		push_request(mk_req(MODE_RESTART, 11'($urandom), 16'($urandom), $urandom,
			1'($urandom)));
		n_entries = $urandom_range(1, 24);
		for (int k = 0; k < n_entries; k++) begin
			while ($urandom_range(0, 7) == 0) push_request(pointer_read());
			if ($urandom_range(0, 24) == 0)
				push_request(mk_req(MODE_SPARE, 11'($urandom), 16'($urandom), $urandom,
					1'($urandom)));
			rq = ($urandom_range(0, 9) < 8) ? wellformed_entry() : noise_entry();
			rq.last = (k == n_entries - 1) && ($urandom_range(0, 7) != 0);
			push_request(rq);
		end
		repeat ($urandom_range(1, 4))
			push_request(($urandom_range(0, 3) == 0) ? wellformed_entry() : pointer_read());
	endtask

	initial begin
		forever begin
			if (!no_idle && $urandom_range(0, 2) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		result_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got.csr_pos = m_tdata[15:0];
			got.ell_slot = m_tdata[41:16];
			got.col = m_tdata[57:42];
			got.value = m_tdata[89:58];
			got.row_start = m_tdata[106:90];
			got.longest = m_tdata[123:107];
			got.status = status_t'(m_tuser);
			if (pending_results.size() == 0) begin
				report_mismatch("result with no request waiting", got.status, 0);
			end else begin
				want = pending_results.pop_front();
				if (got.csr_pos !== want.csr_pos)
					report_mismatch("csr_position", got.csr_pos, want.csr_pos);
				if (got.ell_slot !== want.ell_slot)
					report_mismatch("ell_slot", got.ell_slot, want.ell_slot);
				if (got.col !== want.col)
					report_mismatch("col_out", got.col, want.col);
				if (got.value !== want.value)
					report_mismatch("value_out", got.value, want.value);
				if (got.row_start !== want.row_start)
					report_mismatch("row_start", got.row_start, want.row_start);
				if (got.longest !== want.longest)
					report_mismatch("longest_row", got.longest, want.longest);
				if (got.status !== want.status)
					report_mismatch("status", got.status, want.status);
			end
			results_seen++;
		end
	end

	initial begin
		int unsigned directed_count;
		for (int i = 0; i <= MAX_ROWS; i++) begin
			ptr_tab[i] = '0;
			ptr_set[i] = 1'b0;
		end

		directed.push_back(req_typed(mk_req(MODE_READ, 11'd2, 16'd0, 32'd0, 1'b0),
			res(0, 0, 0, 0, 0, 0, ST_RANGE)));
		directed.push_back(req_typed(mk_req(MODE_SPARE, 11'd0, 16'd0, 32'd0, 1'b0),
			res(0, 0, 0, 0, 0, 0, ST_RANGE)));
		directed.push_back(req_typed(mk_req(MODE_LOAD, 11'd0, 16'd0, 32'hFFFF_FFFF, 1'b0),
			res(0, 0, 0, 32'hFFFF_FFFF, 0, 1, ST_OK)));
		directed.push_back(req_typed(mk_req(MODE_LOAD, 11'd0, 16'd0, 32'd1, 1'b0),
			res(0, 0, 0, 0, 0, 1, ST_ORDER)));
		directed.push_back(req_typed(mk_req(MODE_LOAD, 11'd1, 16'd0, 32'd2, 1'b0),
			res(0, 0, 0, 0, 0, 1, ST_RANGE)));
		directed.push_back(req_typed(mk_req(MODE_LOAD, 11'd0, 16'd1, 32'd3, 1'b0),
			res(0, 0, 0, 0, 0, 1, ST_RANGE)));
		// A refused entry that carries the end marker still closes the conversion.
		directed.push_back(req_typed(mk_req(MODE_LOAD, 11'd2047, 16'hFFFF, 32'd0, 1'b1),
			res(0, 0, 0, 0, 0, 1, ST_RANGE)));
		directed.push_back(req_typed(mk_req(MODE_READ, 11'd1, 16'd0, 32'd0, 1'b0),
			res(0, 0, 0, 0, 1, 1, ST_OK)));
		directed.push_back(req_typed(mk_req(MODE_LOAD, 11'd0, 16'd0, 32'd4, 1'b0),
			res(0, 0, 0, 0, 0, 1, ST_FULL)));
		directed.push_back(req_typed(mk_req(MODE_RESTART, 11'd0, 16'd0, 32'd0, 1'b0),
			res(0, 0, 0, 0, 0, 0, ST_OK)));
		directed.push_back(cfg_step(REG_ROWS, 17'd4));
		directed.push_back(cfg_step(REG_COLS, 17'd8));
		directed.push_back(req_step(mk_req(MODE_LOAD, 11'd1, 16'd3, 32'h3F80_0000, 1'b0)));
		directed.push_back(req_step(mk_req(MODE_LOAD, 11'd1, 16'd5, 32'hBF80_0000, 1'b0)));
		directed.push_back(req_step(mk_req(MODE_LOAD, 11'd1, 16'd4, 32'h0000_0001, 1'b0)));
		directed.push_back(req_step(mk_req(MODE_LOAD, 11'd0, 16'd7, 32'h0000_0002, 1'b0)));
		directed.push_back(req_step(mk_req(MODE_LOAD, 11'd3, 16'd7, 32'h7F80_0000, 1'b0)));
		directed.push_back(req_step(mk_req(MODE_READ, 11'd2, 16'd0, 32'd0, 1'b0)));
		directed.push_back(req_step(mk_req(MODE_LOAD, 11'd3, 16'd7, 32'h0000_0003, 1'b1)));
		directed.push_back(req_step(mk_req(MODE_READ, 11'd4, 16'd0, 32'd0, 1'b0)));
		directed.push_back(req_step(mk_req(MODE_READ, 11'd5, 16'd0, 32'd0, 1'b0)));
		directed.push_back(req_step(mk_req(MODE_RESTART, 11'd0, 16'd0, 32'd0, 1'b0)));
		directed.push_back(req_step(mk_req(MODE_LOAD, 11'd2, 16'd0, 32'h8000_0001, 1'b1)));
		directed.push_back(req_step(mk_req(MODE_READ, 11'd3, 16'd0, 32'd0, 1'b0)));
		directed.push_back(cfg_step(REG_ROWS, 17'd0));
		directed.push_back(cfg_step(REG_COLS, 17'd0));
		directed.push_back(req_step(mk_req(MODE_RESTART, 11'd0, 16'd0, 32'd0, 1'b0)));
		directed.push_back(req_step(mk_req(MODE_LOAD, 11'd0, 16'd0, 32'h7FC0_0000, 1'b1)));
		directed.push_back(cfg_step(REG_ROWS, 17'd2047));
		directed.push_back(cfg_step(REG_COLS, 17'd131071));
		directed.push_back(req_step(mk_req(MODE_RESTART, 11'd0, 16'd0, 32'd0, 1'b0)));
		directed.push_back(req_step(mk_req(MODE_LOAD, 11'd1023, 16'hFFFF, 32'h8000_0000,
			1'b1)));
		directed.push_back(req_step(mk_req(MODE_READ, 11'd1024, 16'd0, 32'd0, 1'b0)));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < directed.size(); i++) begin
			if (directed[i].is_cfg) begin
				wait_results_drained();
				write_reg(directed[i].ridx, directed[i].cdata,
					(i + 1 < directed.size()) && directed[i + 1].is_cfg);
			end else begin
				push_request(directed[i].rq, directed[i].typed, directed[i].want);
			end
		end
		directed_count = requests_sent;

		while (requests_sent < directed_count + 950) begin
			if (requests_sent > directed_count + 800) no_idle = 1'b1;
			run_conversion();
		end
		no_idle = 1'b1;

		wait_results_drained();
		repeat (1100) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch("results never delivered", pending_results.size(), 0);

		$display("Sent %0d requests (%0d directed) and checked %0d results.",
			requests_sent, directed_count, results_seen);
		$display("Closed %0d conversions under random row and column limits.",
			conversions);
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
